### design/postfix_expression_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Postfix expression evaluator assertion macros
// Shorthand for the concurrent checks at the end of the evaluator top level.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH

// Check a condition at every clock edge outside reset
`define PEE_ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Check that a condition implies another in the same cycle
`define PEE_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define PEE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/pee_pkg.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator package
// Character codes, status codes, state and iterative unit types.
// ----------------------------------------------------------------------------
package pee_pkg;

    // Characters that the evaluator decodes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam int WORD_W = 32;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_EMIT
    } t_state;

    // Operations of the iterative unit
    typedef enum logic {
        ALU_DIV,
        ALU_POW
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_rsp;

endpackage

### design/pee_if.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator channels
// Valid/ready channels for input characters and for expression results.
// ----------------------------------------------------------------------------
interface pee_tok_if;
    logic       valid;
    logic       ready;
    logic [7:0] token;
    logic       last;

    modport source (output valid, output token, output last, input ready);
    modport sink   (input valid, input token, input last, output ready);
endinterface

interface pee_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic        [2:0]  status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

### design/postfix_expression_evaluator.sv
// A digit is pushed when taken; +, -, * and unknown characters pass S_EXEC (read, writeback).
// Divide and power wait in S_WAIT on the iterative unit, which retires one bit a cycle.
// An item flagged last ends in S_EMIT, which waits for a free slot; its result is registered.
// Characters are taken one at a time, only in S_IDLE, so each waits for the previous one.
// Reset (synchronous, active low) empties the stack, clears the error and the output slot.
// The stack memory needs no clearing pass: only entries below the pointer are read.
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Operand stack in a RAM with the top entry cached in a register.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pee_tok_if.sink   i_tok,
    pee_res_if.source o_res
);
    import pee_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    t_state            r_state, n_state;
    logic [SPW-1:0]    r_sp, n_sp;
    t_status           r_err, n_err;
    logic [WORD_W-1:0] r_tos, n_tos;
    logic [7:0]        r_op, n_op;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_value, n_out_value;
    t_status           r_out_status, n_out_status;

    logic              tok_acc;
    logic              is_digit;
    logic              full;
    logic              few;
    logic              op_go;
    logic              slot_free;
    logic              div_zero;
    logic              long_op;
    logic [SPW-1:0]    sp_m2;
    logic [WORD_W-1:0] digit_val;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic [WORD_W-1:0] alu_result;

    // Stack storage; the top entry is also cached in r_tos
    pee_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (sp_m2[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Divide and power unit
    pee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (ram_rdata),
        .i_b      (r_tos),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    // Decode the incoming character and stack conditions
    always_comb begin
        tok_acc   = i_tok.valid && i_tok.ready;
        is_digit  = i_tok.token inside {[CH_ZERO:CH_NINE]};
        digit_val = WORD_W'(i_tok.token - CH_ZERO);
        full      = (r_sp >= SPW'(STACK_DEPTH));
        few       = (r_sp < SPW'(2));
        op_go     = (r_err == ST_OK) && !is_digit && !few;
        sp_m2     = r_sp - SPW'(2);
        slot_free = !r_out_valid || o_res.ready;
        div_zero  = (r_op == CH_SLASH) && (r_tos == '0);
        long_op   = ((r_op == CH_SLASH) && !div_zero) || (r_op == CH_CARET);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tok_acc) begin
                    if (op_go) begin
                        n_state = S_EXEC;
                    end else if (i_tok.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EXEC: begin
                if (long_op) begin
                    n_state = S_WAIT;
                end else begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        i_tok.ready  = (r_state == S_IDLE);
        n_sp         = r_sp;
        n_err        = r_err;
        n_tos        = r_tos;
        n_op         = r_op;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_sp[AW-1:0];
        ram_wdata    = digit_val;
        alu_req      = '{start: 1'b0, op: ALU_DIV};
        case (r_state)
            S_IDLE: begin
                if (tok_acc) begin
                    n_op   = i_tok.token;
                    n_last = i_tok.last;
                    if (r_err == ST_OK) begin
                        if (is_digit) begin
                            if (full) begin
                                n_err = ST_FULL;
                            end else begin
                                // push: the new top goes to memory and the cache
                                ram_we = 1'b1;
                                n_tos  = digit_val;
                                n_sp   = r_sp + 1'b1;
                            end
                        end else if (few) begin
                            n_err = ST_UNDERFLOW;
                        end
                    end
                end
            end
            S_EXEC: begin
                ram_waddr = sp_m2[AW-1:0];
                case (r_op)
                    CH_PLUS:  ram_wdata = ram_rdata + r_tos;
                    CH_MINUS: ram_wdata = ram_rdata - r_tos;
                    CH_STAR:  ram_wdata = ram_rdata * r_tos;
                    default:  ram_wdata = '0;
                endcase
                if (div_zero) begin
                    n_err = ST_DIVZERO;
                end else if (long_op) begin
                    alu_req = '{start: 1'b1, op: (r_op == CH_SLASH) ? ALU_DIV : ALU_POW};
                end else begin
                    // pop two, push the result
                    ram_we = 1'b1;
                    n_tos  = ram_wdata;
                    n_sp   = r_sp - 1'b1;
                end
            end
            S_WAIT: begin
                ram_waddr = sp_m2[AW-1:0];
                ram_wdata = alu_result;
                if (alu_rsp.done) begin
                    ram_we = 1'b1;
                    n_tos  = alu_result;
                    n_sp   = r_sp - 1'b1;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    if (r_err != ST_OK) begin
                        n_out_status = r_err;
                        n_out_value  = '0;
                    end else if (r_sp == '0) begin
                        n_out_status = ST_EMPTY;
                        n_out_value  = '0;
                    end else begin
                        n_out_status = ST_OK;
                        n_out_value  = r_tos;
                    end
                    // drop the expression
                    n_sp  = '0;
                    n_err = ST_OK;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_tos        <= n_tos;
        r_op         <= n_op;
        r_last       <= n_last;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.value  = r_out_value;
    assign o_res.status = r_out_status;

    `PEE_ASSERT_ALWAYS(a_sp_bound, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH), "stack pointer past depth")
    `PEE_ASSERT_IMPLY(a_start_exec, i_clk, i_rst_n, alu_req.start, r_state == S_EXEC, "unit start outside execute")
    `PEE_ASSERT_IMPLY(a_busy_wait, i_clk, i_rst_n, alu_rsp.busy, r_state == S_WAIT, "unit busy while sequencer moved on")
    `PEE_ASSERT_NEXT(a_emit_clear, i_clk, i_rst_n, (r_state == S_EMIT) && slot_free, (r_sp == '0) && (r_err == ST_OK), "stack not cleared after result")
    `PEE_ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_res.valid && (o_res.status != ST_OK), o_res.value == '0, "error result carries a value")

endmodule

### design/pee_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### design/pee_alu.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator iterative unit
// Signed divide (one quotient bit per cycle) and square-and-multiply power.
// ----------------------------------------------------------------------------
module pee_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pee_pkg::t_alu_req i_req,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output pee_pkg::t_alu_rsp o_rsp,
    output logic [31:0]       o_result
);
    import pee_pkg::*;

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic             r_busy;
    logic             r_done;
    t_alu_op          r_op;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    // Divide: remainder, dividend/quotient, divisor. Power: product, base, exponent.
    logic [WORD_W-1:0] r_p;
    logic [WORD_W-1:0] r_q;
    logic [WORD_W-1:0] r_d;
    logic [WORD_W-1:0] r_res;

    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              fits;
    logic [WORD_W-1:0] abs_a;
    logic [WORD_W-1:0] abs_b;

    // Magnitudes and one restoring step
    always_comb begin
        abs_a = i_a[WORD_W-1] ? (~i_a + 1'b1) : i_a;
        abs_b = i_b[WORD_W-1] ? (~i_b + 1'b1) : i_b;
        trial = {r_p, r_q[WORD_W-1]};
        diff  = trial - {1'b0, r_d};
        fits  = (trial >= {1'b0, r_d});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if ((r_op == ALU_DIV && r_cnt == CNT_W'(WORD_W)) ||
                    (r_op == ALU_POW && r_d == '0)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_cnt <= '0;
            r_neg <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
            if (i_req.op == ALU_DIV) begin
                r_p <= '0;
                r_q <= abs_a;
                r_d <= abs_b;
            end else begin
                r_p <= WORD_W'(1);
                r_q <= i_a;
                // negative exponent gives one
                r_d <= i_b[WORD_W-1] ? '0 : i_b;
            end
        end else if (r_busy) begin
            if (r_op == ALU_DIV) begin
                if (r_cnt == CNT_W'(WORD_W)) begin
                    r_res <= r_neg ? (~r_q + 1'b1) : r_q;
                end else begin
                    r_p   <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                    r_q   <= {r_q[WORD_W-2:0], fits};
                    r_cnt <= r_cnt + 1'b1;
                end
            end else begin
                if (r_d == '0) begin
                    r_res <= r_p;
                end else begin
                    if (r_d[0]) begin
                        r_p <= r_p * r_q;
                    end
                    r_q <= r_q * r_q;
                    r_d <= r_d >> 1;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = r_res;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// Postfix expression evaluator testbench
// Feeds expressions one character at a time through the token channel and
// checks each result against an in-bench calculator that tracks the operand
// stack, the stack pointer and the first error of every expression. A
// short directed set covers the corner cases. Random well-formed
// expressions, deep pushes, noise and broken sequences follow.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pee_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int RANDOM_CHARS  = 1650;
    localparam int TAIL_CHARS    = 120;
    localparam int DRAIN_CYCLES  = 60;
    localparam int TIMEOUT_NS    = 5_000_000;

    localparam logic [7:0] TOK_NUL = 8'h00;
    localparam logic [7:0] TOK_MAX = 8'hFF;

    typedef struct packed {
        logic [7:0] token;
        logic       last;
    } char_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        t_status            status;
    } eval_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pee_tok_if tok_if ();
    pee_res_if res_if ();

    postfix_expression_evaluator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if),
        .o_res   (res_if)
    );

    // Calculator state
    logic [31:0]  calc_stack [STACK_DEPTH];
    int unsigned  calc_sp;
    t_status      calc_err;

    char_item_t   pending_chars [$];
    eval_result_t expected_results [$];
    logic [7:0]   expr_buf [$];

    int n_fail;
    int n_chars_sent;
    int n_exprs;
    int n_results;
    int n_ok_results;
    int status_seen [5];

    // Idle control
    int src_gap;
    int src_idle_pct;
    int snk_gap;
    int snk_idle_pct;
    int snk_cycles;

    // ------------------------------------------------------------------------
    // Calculator
    // ------------------------------------------------------------------------

    // Raise to a power modulo 2^32, 1 for a negative exponent
    function automatic logic [31:0] power_mod32(logic [31:0] base, logic [31:0] expo);
        logic [31:0] acc;
        logic [31:0] sq;
        acc = 32'd1;
        sq  = base;
        if (expo[31]) begin
            return 32'd1;
        end
        for (int i = 0; i < 31; i++) begin
            if (expo[i]) begin
                acc = acc * sq;
            end
            sq = sq * sq;
        end
        return acc;
    endfunction

    // Apply one accepted character and queue the result on the last one
    function automatic void evaluate_char(logic [7:0] tok, logic last);
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  r;
        longint       qa;
        longint       qb;
        longint       q;
        eval_result_t res;
        if (calc_err == ST_OK) begin
            if (tok >= CH_ZERO && tok <= CH_NINE) begin
                if (calc_sp >= STACK_DEPTH) begin
                    calc_err = ST_FULL;
                end else begin
                    calc_stack[calc_sp] = {24'd0, tok - CH_ZERO};
                    calc_sp++;
                end
            end else if (calc_sp < 2) begin
                calc_err = ST_UNDERFLOW;
            end else begin
                b = calc_stack[calc_sp - 1];
                a = calc_stack[calc_sp - 2];
                r = '0;
                case (tok)
                    CH_PLUS:  r = a + b;
                    CH_MINUS: r = a - b;
                    CH_STAR:  r = a * b;
                    CH_SLASH: begin
                        if (b == '0) begin
                            calc_err = ST_DIVZERO;
                        end else begin
                            qa = longint'($signed(a));
                            qb = longint'($signed(b));
                            q  = qa / qb;
                            r  = q[31:0];
                        end
                    end
                    CH_CARET: r = power_mod32(a, b);
                    default:  r = '0;
                endcase
                if (calc_err == ST_OK) begin
                    calc_sp--;
                    calc_stack[calc_sp - 1] = r;
                end
            end
        end
        if (last) begin
            res.value = '0;
            if (calc_err != ST_OK) begin
                res.status = calc_err;
            end else if (calc_sp == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = ST_OK;
                res.value  = calc_stack[calc_sp - 1];
            end
            expected_results.push_back(res);
            calc_sp  = 0;
            calc_err = ST_OK;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Expression builders
    // ------------------------------------------------------------------------

    function automatic logic [7:0] digit_char(int unsigned d);
        return CH_ZERO + 8'(d);
    endfunction

    function automatic logic [7:0] random_digit();
        return digit_char($urandom_range(0, 9));
    endfunction

    // Pick any byte that decodes as neither a digit nor a known operator
    function automatic logic [7:0] unknown_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
                   c == CH_STAR || c == CH_SLASH || c == CH_CARET);
        return c;
    endfunction

    // Give plus, minus, multiply and power twice the weight of divide and unknown characters
    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 9))
            0, 1:    return CH_PLUS;
            2, 3:    return CH_MINUS;
            4, 5:    return CH_STAR;
            6:       return CH_SLASH;
            7, 8:    return CH_CARET;
            default: return unknown_char();
        endcase
    endfunction

    // Move the built expression to the pending queue, last flag on its end
    task automatic close_expr();
        char_item_t item;
        while (expr_buf.size() != 0) begin
            item.token = expr_buf.pop_front();
            item.last  = (expr_buf.size() == 0);
            pending_chars.push_back(item);
        end
        n_exprs++;
    endtask

    task automatic build_wellformed();
        int depth;
        int ops_left;
        depth    = 0;
        ops_left = $urandom_range(0, 12);
        while (ops_left > 0 || depth != 1) begin
            if (depth < 2 || (ops_left > 0 && depth < 8 && $urandom_range(0, 1) == 1)) begin
                expr_buf.push_back(random_digit());
                depth++;
            end else begin
                expr_buf.push_back(random_operator());
                depth--;
                if (ops_left > 0) begin
                    ops_left--;
                end
            end
        end
    endtask

    // Push close to or past the stack depth, then fold it back down
    task automatic build_deep_push();
        int n;
        n = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 2);
        repeat (n) expr_buf.push_back(random_digit());
        repeat (n - 1) expr_buf.push_back(random_operator());
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 6)) expr_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_broken();
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 1) == 1) begin
                expr_buf.push_back(random_digit());
            end else begin
                expr_buf.push_back(random_operator());
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Token driver: predict on every accepted transaction, then load the next
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        char_item_t item;
        if (!i_rst_n) begin
            tok_if.valid <= 1'b0;
            tok_if.token <= TOK_NUL;
            tok_if.last  <= 1'b0;
            src_gap      <= 0;
        end else begin
            if (tok_if.valid && tok_if.ready) begin
                evaluate_char(tok_if.token, tok_if.last);
            end
            if (!tok_if.valid || tok_if.ready) begin
                if (src_gap > 0) begin
                    tok_if.valid <= 1'b0;
                    src_gap      <= src_gap - 1;
                end else if (pending_chars.size() != 0) begin
                    item = pending_chars.pop_front();
                    tok_if.valid <= 1'b1;
                    tok_if.token <= item.token;
                    tok_if.last  <= item.last;
                    n_chars_sent++;
                    if (n_chars_sent % 50 == 0) begin
                        case ($urandom_range(0, 2))
                            0:       src_idle_pct = 0;
                            1:       src_idle_pct = 15;
                            default: src_idle_pct = 40;
                        endcase
                    end
                    if (pending_chars.size() > TAIL_CHARS && src_idle_pct != 0 &&
                        $urandom_range(1, 100) <= src_idle_pct) begin
                        src_gap <= $urandom_range(1, 11);
                    end
                end else begin
                    tok_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check against the oldest expectation, stall at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        eval_result_t exp_res;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            snk_gap      <= 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("unexpected result: value %0d status %0d",
                           res_if.value, res_if.status);
                    n_fail++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (res_if.value !== exp_res.value) begin
                        $error("value: expected %0d, actual %0d", exp_res.value, res_if.value);
                        n_fail++;
                    end
                    if (res_if.status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, res_if.status);
                        n_fail++;
                    end
                    if (exp_res.status == ST_OK) begin
                        n_ok_results++;
                    end
                    status_seen[exp_res.status]++;
                end
            end
            // Redraw the stall rate now and then, with stall-free stretches
            snk_cycles++;
            if (snk_cycles % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       snk_idle_pct = 0;
                    1:       snk_idle_pct = 10;
                    default: snk_idle_pct = 35;
                endcase
            end
            if (snk_gap > 0) begin
                res_if.ready <= 1'b0;
                snk_gap      <= snk_gap - 1;
            end else if (pending_chars.size() > TAIL_CHARS && snk_idle_pct != 0 &&
                         $urandom_range(1, 100) <= snk_idle_pct) begin
                res_if.ready <= 1'b0;
                snk_gap      <= $urandom_range(0, 10);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------------
    initial begin
        #TIMEOUT_NS;
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int kind;
        int target;
        tok_if.valid = 1'b0;
        tok_if.token = TOK_NUL;
        tok_if.last  = 1'b0;
        res_if.ready = 1'b0;
        calc_sp      = 0;
        calc_err     = ST_OK;
        n_fail       = 0;
        n_chars_sent = 0;
        n_exprs      = 0;
        n_results    = 0;
        n_ok_results = 0;
        src_gap      = 0;
        snk_gap      = 0;
        snk_cycles   = 0;
        src_idle_pct = 15;
        snk_idle_pct = 10;
        foreach (status_seen[i]) status_seen[i] = 0;

        // Most negative value divided by minus one: (2 ^ (5*6+1)) / (0-1)
        expr_buf = '{digit_char(2), digit_char(5), digit_char(6), CH_STAR, digit_char(1),
                     CH_PLUS, CH_CARET, digit_char(0), digit_char(1), CH_MINUS, CH_SLASH};
        close_expr();
        // Negative exponent gives one
        expr_buf = '{digit_char(2), digit_char(0), digit_char(1), CH_MINUS, CH_CARET};
        close_expr();
        // Zero to the zero, then an unknown operator on the all-ones byte
        expr_buf = '{digit_char(0), digit_char(0), CH_CARET, digit_char(7), TOK_MAX};
        close_expr();
        // Lone operator on the all-zeros byte underflows
        expr_buf = '{TOK_NUL};
        close_expr();
        // Divide by zero, then characters that the sticky error swallows
        expr_buf = '{digit_char(9), digit_char(0), CH_SLASH, digit_char(3), CH_PLUS};
        close_expr();

        // Random part: mostly well-formed expressions
        target = pending_chars.size() + RANDOM_CHARS;
        while (pending_chars.size() < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                build_wellformed();
            end else if (kind < 80) begin
                build_deep_push();
            end else if (kind < 90) begin
                build_noise();
            end else begin
                build_broken();
            end
            close_expr();
        end

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all characters in, every expected result out
        while (pending_chars.size() != 0 || tok_if.valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d characters in %0d expressions, %0d results (%0d ok)",
                 n_chars_sent, n_exprs, n_results, n_ok_results);
        $display("Summary: underflow %0d, divide by zero %0d, stack full %0d, empty %0d",
                 status_seen[ST_UNDERFLOW], status_seen[ST_DIVZERO],
                 status_seen[ST_FULL], status_seen[ST_EMPTY]);
        if (n_fail == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/pee_pkg.sv
design/pee_if.sv
design/pee_ram.sv
design/pee_alu.sv
design/postfix_expression_evaluator.sv
test/tb_top.sv
